// ===== hw/rtl/modbus_rtu_read_transaction_assert.svh =====
// Assertion macros shared by the Modbus RTU read transaction RTL.
// Each macro expects clk and rst_n in scope.
`ifndef MODBUS_RTU_READ_TRANSACTION_ASSERT_SVH
`define MODBUS_RTU_READ_TRANSACTION_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define MRTU_ASSERT_SAME(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) else $error(msg);

// Condition implies consequence in the following cycle.
`define MRTU_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mrtu_pkg.sv =====
// ----------------------------------------------------------------------------
// mrtu_pkg
// Types, constants and the CRC-16 byte step for the Modbus RTU read block.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int BANKS       = 4;
  localparam int BANK_DEPTH  = STORE_DEPTH / BANKS;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RW_BYTE  = 2'd0,
    RW_WORD  = 2'd1,
    RW_DWORD = 2'd2,
    RW_BIT   = 2'd3
  } rw_t;

  typedef enum logic [1:0] {
    OUTC_OK      = 2'd0,
    OUTC_CRC     = 2'd1,
    OUTC_TIMEOUT = 2'd2
  } outc_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_CRC    = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    KIND_START = 3'b001,
    KIND_DONE  = 3'b010,
    KIND_READ  = 3'b100
  } kind_t;

  // Start: {dev, func, start_reg, reg_count}. Done: outcome at [9:8], length
  // at [7:0]. Read: error at [32], value at [31:0].
  typedef struct packed {
    kind_t       kind;
    logic [47:0] data;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/mrtu_ram.sv =====
// ----------------------------------------------------------------------------
// mrtu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mrtu_queue.sv =====
// ----------------------------------------------------------------------------
// mrtu_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module mrtu_queue
  import mrtu_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  q_push_t        push_in,
  input  logic           deq,
  output q_entry_t       head,
  output logic           q_empty,
  output logic [QAW:0]   level
);

  q_entry_t        ent_r [QDEPTH];
  logic [QAW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QAW:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = push_in.valid ? wr_r + 1'b1 : wr_r;
    rd_nxt  = deq ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + {{QAW{1'b0}}, push_in.valid} - {{QAW{1'b0}}, deq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push_in.valid) begin
      ent_r[wr_r] <= push_in.entry;
    end
  end

  assign head    = ent_r[rd_r];
  assign q_empty = (cnt_r == '0);
  assign level   = cnt_r;

endmodule

// ===== hw/rtl/mrtu_front.sv =====
// ----------------------------------------------------------------------------
// mrtu_front
// Accepts items, tracks the receive state, stores data bytes and queues work.
// ----------------------------------------------------------------------------
module mrtu_front
  import mrtu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [1:0]   op,
  input  logic [7:0]   dev_addr,
  input  logic [7:0]   func_code,
  input  logic [15:0]  start_reg,
  input  logic [15:0]  reg_count,
  input  logic [7:0]   rx_byte,
  input  logic [15:0]  read_index,
  input  logic         read_by_register,
  input  logic [1:0]   read_width,
  input  logic [2:0]   bit_index,
  input  logic [15:0]  timeout_ticks,
  input  logic [QAW:0] level,
  output logic         busy_full,
  output q_push_t      push_out
);

  phase_t       phase_r, phase_nxt;
  logic [1:0]   hc_r, hc_nxt;
  logic [7:0]   dc_r, dc_nxt;
  logic [7:0]   flen_r, flen_nxt;
  logic [15:0]  crc_r, crc_nxt;
  logic [7:0]   low_r, low_nxt;
  logic [15:0]  sr_r, sr_nxt;
  logic [15:0]  ticks_r, ticks_nxt;

  // Stage between RAM read and queue push.
  logic         st_v_r, st_v_nxt;
  kind_t        st_kind_r, st_kind_nxt;
  logic [47:0]  st_data_r, st_data_nxt;
  logic         st_err_r, st_err_nxt;
  logic [1:0]   st_lane_r, st_lane_nxt;
  logic [1:0]   st_w_r, st_w_nxt;
  logic [2:0]   st_bit_r, st_bit_nxt;

  logic [15:0]  crc_in;
  logic [16:0]  diff;
  logic [17:0]  off, off_end;
  logic [2:0]   nbytes;
  logic [8:0]   avail;
  logic         rd_err;
  logic         wr_en;
  logic [7:0]   rd_data [BANKS];
  logic [BANK_AW-1:0] rd_addr [BANKS];

  assign crc_in = crc_byte(crc_r, rx_byte);
  assign wr_en  = accept && (op_t'(op) == OP_BYTE) && (phase_r == PH_DATA) &&
                  ({1'b0, dc_r} < 9'(STORE_DEPTH));

  always_comb begin
    diff   = {1'b0, read_index} - {1'b0, sr_r};
    nbytes = (rw_t'(read_width) == RW_WORD) ? 3'd2 :
             (rw_t'(read_width) == RW_DWORD) ? 3'd4 : 3'd1;
    if (read_by_register) begin
      off = (rw_t'(read_width) == RW_WORD || rw_t'(read_width) == RW_DWORD) ?
            {1'b0, diff[15:0], 1'b0} : {2'b00, diff[15:0]};
    end else begin
      off = {2'b00, read_index};
    end
    off_end = off + {15'd0, nbytes};
    avail   = ({1'b0, dc_r} < 9'(STORE_DEPTH)) ? {1'b0, dc_r} : 9'(STORE_DEPTH);
    rd_err  = (read_by_register && diff[16]) || (off_end > {9'd0, avail});
  end

  // Byte k of a read lives in bank (off + k) mod BANKS.
  always_comb begin
    logic [8:0] sum;
    for (int j = 0; j < BANKS; j++) begin
      sum = {1'b0, off[7:0]} + {7'd0, 2'(j) - off[1:0]};
      rd_addr[j] = sum[BANK_AW+1:2];
    end
  end

  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    mrtu_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
      .clk   (clk),
      .we    (wr_en && (dc_r[1:0] == 2'(g))),
      .waddr (dc_r[BANK_AW+1:2]),
      .wdata (rx_byte),
      .raddr (rd_addr[g]),
      .rdata (rd_data[g])
    );
  end

  always_comb begin
    phase_nxt   = phase_r;
    hc_nxt      = hc_r;
    dc_nxt      = dc_r;
    flen_nxt    = flen_r;
    crc_nxt     = crc_r;
    low_nxt     = low_r;
    sr_nxt      = sr_r;
    ticks_nxt   = ticks_r;
    st_v_nxt    = 1'b0;
    st_kind_nxt = KIND_DONE;
    st_data_nxt = '0;
    st_err_nxt  = rd_err;
    st_lane_nxt = off[1:0];
    st_w_nxt    = read_width;
    st_bit_nxt  = bit_index;
    if (accept) begin
      case (op_t'(op))
        OP_START: begin
          st_v_nxt    = 1'b1;
          st_kind_nxt = KIND_START;
          st_data_nxt = {dev_addr, func_code, start_reg, reg_count};
          sr_nxt      = start_reg;
          phase_nxt   = PH_HEADER;
          hc_nxt      = '0;
          dc_nxt      = '0;
          flen_nxt    = '0;
          crc_nxt     = CRC_INIT;
          low_nxt     = '0;
          ticks_nxt   = '0;
        end
        OP_BYTE: begin
          case (phase_r)
            PH_HEADER: begin
              crc_nxt = crc_in;
              if (hc_r >= 2'd2) begin
                flen_nxt  = rx_byte;
                hc_nxt    = '0;
                phase_nxt = (rx_byte == 8'd0) ? PH_CRC : PH_DATA;
              end else begin
                hc_nxt = hc_r + 2'd1;
              end
            end
            PH_DATA: begin
              crc_nxt = crc_in;
              dc_nxt  = dc_r + 8'd1;
              if (dc_r + 8'd1 >= flen_r) begin
                hc_nxt    = '0;
                phase_nxt = PH_CRC;
              end
            end
            PH_CRC: begin
              if (hc_r == 2'd0) begin
                low_nxt = rx_byte;
                hc_nxt  = 2'd1;
              end else begin
                hc_nxt      = '0;
                phase_nxt   = PH_IDLE;
                st_v_nxt    = 1'b1;
                st_data_nxt = {38'd0,
                               ({rx_byte, low_r} == crc_r) ? OUTC_OK : OUTC_CRC,
                               flen_r};
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (ticks_r >= timeout_ticks) begin
              phase_nxt   = PH_IDLE;
              st_v_nxt    = 1'b1;
              st_data_nxt = {38'd0, OUTC_TIMEOUT, flen_r};
            end else begin
              ticks_nxt = ticks_r + 16'd1;
            end
          end
        end
        default: begin
          st_v_nxt    = 1'b1;
          st_kind_nxt = KIND_READ;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hc_r    <= '0;
      dc_r    <= '0;
      flen_r  <= '0;
      crc_r   <= CRC_INIT;
      low_r   <= '0;
      sr_r    <= '0;
      ticks_r <= '0;
      st_v_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      dc_r    <= dc_nxt;
      flen_r  <= flen_nxt;
      crc_r   <= crc_nxt;
      low_r   <= low_nxt;
      sr_r    <= sr_nxt;
      ticks_r <= ticks_nxt;
      st_v_r  <= st_v_nxt;
    end
    st_kind_r <= st_kind_nxt;
    st_data_r <= st_data_nxt;
    st_err_r  <= st_err_nxt;
    st_lane_r <= st_lane_nxt;
    st_w_r    <= st_w_nxt;
    st_bit_r  <= st_bit_nxt;
  end

  // Assemble the read value from the rotated bank outputs.
  always_comb begin
    logic [7:0]  b0, b1, b2, b3;
    logic [31:0] val;
    b0 = rd_data[st_lane_r];
    b1 = rd_data[st_lane_r + 2'd1];
    b2 = rd_data[st_lane_r + 2'd2];
    b3 = rd_data[st_lane_r + 2'd3];
    case (rw_t'(st_w_r))
      RW_BYTE:  val = {24'd0, b0};
      RW_WORD:  val = {16'd0, b0, b1};
      RW_DWORD: val = {b0, b1, b2, b3};
      default:  val = {31'd0, b0[st_bit_r]};
    endcase
    push_out.valid      = st_v_r;
    push_out.entry.kind = st_kind_r;
    if (st_kind_r == KIND_READ) begin
      push_out.entry.data = {15'd0, st_err_r, st_err_r ? 32'd0 : val};
    end else begin
      push_out.entry.data = st_data_r;
    end
  end

  // One slot is reserved for the transaction sitting in the stage.
  assign busy_full = ({1'b0, level} + {{QAW+1{1'b0}}, st_v_r}) >= (QAW+2)'(QDEPTH);

endmodule

// ===== hw/rtl/mrtu_back.sv =====
// ----------------------------------------------------------------------------
// mrtu_back
// Turns queued commands into results; expands a start into the 8-byte request.
// ----------------------------------------------------------------------------
module mrtu_back
  import mrtu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_entry_t  head,
  input  logic      q_empty,
  input  logic      pop,
  output logic      deq,
  output logic      tx_valid,
  output logic [7:0] tx_byte,
  output logic      tx_last,
  output logic      frame_done,
  output logic [1:0] outcome,
  output logic [7:0] rx_len,
  output logic      read_valid,
  output logic [31:0] read_value,
  output logic      read_error
);

  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        take, is_start;

  assign is_start = (head.kind == KIND_START);
  assign take     = pop && !q_empty;
  assign deq      = take && (!is_start || cnt_r == 3'd7);

  always_comb begin
    case (cnt_r)
      3'd0:    tx_byte = head.data[47:40];
      3'd1:    tx_byte = head.data[39:32];
      3'd2:    tx_byte = head.data[31:24];
      3'd3:    tx_byte = head.data[23:16];
      3'd4:    tx_byte = head.data[15:8];
      3'd5:    tx_byte = head.data[7:0];
      3'd6:    tx_byte = crc_r[7:0];
      default: tx_byte = crc_r[15:8];
    endcase
  end

  // The request CRC is built one byte per popped request byte.
  always_comb begin
    cnt_nxt = cnt_r;
    crc_nxt = crc_r;
    if (take && is_start) begin
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r < 3'd6) begin
        crc_nxt = crc_byte((cnt_r == 3'd0) ? CRC_INIT : crc_r, tx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    crc_r <= crc_nxt;
  end

  assign tx_valid   = is_start;
  assign tx_last    = is_start && (cnt_r == 3'd7);
  assign frame_done = (head.kind == KIND_DONE);
  assign outcome    = frame_done ? head.data[9:8] : 2'd0;
  assign rx_len     = frame_done ? head.data[7:0] : 8'd0;
  assign read_valid = (head.kind == KIND_READ);
  assign read_value = read_valid ? head.data[31:0] : 32'd0;
  assign read_error = read_valid && head.data[32];

endmodule

// ===== hw/rtl/modbus_rtu_read_transaction.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_read_transaction
// Modbus RTU master for one read transaction, queue-style ports.
// ----------------------------------------------------------------------------
// Input transactions are taken on push while full is low: a start request,
// a received serial byte, a time tick, or a read of the stored response data.
// Results come out in order while empty is low and are removed with pop.
// A start yields eight request bytes, the end of a response or a timeout
// yields one done result, and each read yields one result.
// The front part takes one transaction per cycle while full is low; data bytes go
// to four interleaved byte RAMs so a dword read needs a single RAM read. A result
// is registered in the stage, alongside the RAM read, and then in the queue. The
// back part gives one result per cycle while pop is high and empty is low; a start
// holds the head for all eight request bytes, folding the CRC in byte by byte.
// When the receiver stalls, the four-entry queue fills and full rises.
// Reset empties the queue, returns to idle and sets the timeout to 200.
// The timeout register is written through cfg_we and cfg_wdata.
// ----------------------------------------------------------------------------
module modbus_rtu_read_transaction
  import mrtu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_dev_addr,
  input  logic [7:0]  in_func_code,
  input  logic [15:0] in_start_reg,
  input  logic [15:0] in_reg_count,
  input  logic [7:0]  in_rx_byte,
  input  logic [15:0] in_read_index,
  input  logic        in_read_by_register,
  input  logic [1:0]  in_read_width,
  input  logic [2:0]  in_bit_index,
  output logic        empty,
  input  logic        pop,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_frame_done,
  output logic [1:0]  out_outcome,
  output logic [7:0]  out_rx_len,
  output logic        out_read_valid,
  output logic [31:0] out_read_value,
  output logic        out_read_error
);

  `include "modbus_rtu_read_transaction_assert.svh"

  logic [15:0]  timeout_r;
  logic         accept, deq;
  logic [QAW:0] level;
  q_push_t      q_push;
  q_entry_t     head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  assign accept = push && !full;

  mrtu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .op               (in_op),
    .dev_addr         (in_dev_addr),
    .func_code        (in_func_code),
    .start_reg        (in_start_reg),
    .reg_count        (in_reg_count),
    .rx_byte          (in_rx_byte),
    .read_index       (in_read_index),
    .read_by_register (in_read_by_register),
    .read_width       (in_read_width),
    .bit_index        (in_bit_index),
    .timeout_ticks    (timeout_r),
    .level            (level),
    .busy_full        (full),
    .push_out         (q_push)
  );

  mrtu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_in (q_push),
    .deq     (deq),
    .head    (head),
    .q_empty (empty),
    .level   (level)
  );

  mrtu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (empty),
    .pop        (pop),
    .deq        (deq),
    .tx_valid   (out_tx_valid),
    .tx_byte    (out_tx_byte),
    .tx_last    (out_tx_last),
    .frame_done (out_frame_done),
    .outcome    (out_outcome),
    .rx_len     (out_rx_len),
    .read_valid (out_read_valid),
    .read_value (out_read_value),
    .read_error (out_read_error)
  );

  `MRTU_ASSERT_SAME(a_full_at_cap, level == (QAW+1)'(QDEPTH), full, "queue at capacity but not full")
  `MRTU_ASSERT_NEXT(a_start_staged, accept && in_op == OP_START, q_push.valid && q_push.entry.kind == KIND_START, "start transaction not staged")
  `MRTU_ASSERT_SAME(a_one_kind, !empty, $onehot({out_tx_valid, out_frame_done, out_read_valid}), "result carries no single kind")
  `MRTU_ASSERT_SAME(a_err_zero, !empty && out_read_error, out_read_value == 32'd0, "read error with nonzero value")

endmodule

// ===== verif/modbus_rtu_read_transaction_checker.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_read_transaction_checker
// Watches both queue ports and the timeout register write of the Modbus RTU
// read block. It keeps its own copy of the master's state, works out the
// results of every accepted input transaction and compares each popped
// result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module modbus_rtu_read_transaction_checker
  import mrtu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_dev_addr,
  input  logic [7:0]  in_func_code,
  input  logic [15:0] in_start_reg,
  input  logic [15:0] in_reg_count,
  input  logic [7:0]  in_rx_byte,
  input  logic [15:0] in_read_index,
  input  logic        in_read_by_register,
  input  logic [1:0]  in_read_width,
  input  logic [2:0]  in_bit_index,
  input  logic        empty,
  input  logic        pop,
  input  logic        out_tx_valid,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_tx_last,
  input  logic        out_frame_done,
  input  logic [1:0]  out_outcome,
  input  logic [7:0]  out_rx_len,
  input  logic        out_read_valid,
  input  logic [31:0] out_read_value,
  input  logic        out_read_error,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        frame_done;
    logic [1:0]  outcome;
    logic [7:0]  rx_len;
    logic        read_valid;
    logic [31:0] read_value;
    logic        read_error;
  } result_t;

  result_t     expected_q[$];
  int          errors;

  logic [15:0] timeout_reg;
  phase_t      rx_phase;
  logic [1:0]  hdr_cnt;
  logic [7:0]  data_cnt;
  logic [7:0]  frame_len;
  logic [15:0] rx_crc;
  logic [7:0]  crc_lo;
  logic [15:0] base_reg;
  logic [15:0] tick_cnt;
  logic [7:0]  store [STORE_DEPTH];

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) r = (r >> 1) ^ 16'hA001;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic result_t done_result(input outc_t oc, input logic [7:0] len);
    result_t r;
    r = '0;
    r.frame_done = 1'b1;
    r.outcome = oc;
    r.rx_len = len;
    return r;
  endfunction

  task automatic predict_transaction();
    logic [7:0]  req [8];
    logic [15:0] c;
    result_t     r;
    logic [31:0] off, avail, nbytes, val;
    logic        err;
    rw_t         w;
    case (op_t'(in_op))
      OP_START: begin
        req[0] = in_dev_addr;
        req[1] = in_func_code;
        req[2] = in_start_reg[15:8];
        req[3] = in_start_reg[7:0];
        req[4] = in_reg_count[15:8];
        req[5] = in_reg_count[7:0];
        c = 16'hFFFF;
        for (int k = 0; k < 6; k++) c = crc_step(c, req[k]);
        req[6] = c[7:0];
        req[7] = c[15:8];
        for (int k = 0; k < 8; k++) begin
          r = '0;
          r.tx_valid = 1'b1;
          r.tx_byte = req[k];
          r.tx_last = (k == 7);
          expected_q.push_back(r);
        end
        base_reg = in_start_reg;
        rx_phase = PH_HEADER;
        hdr_cnt = '0;
        data_cnt = '0;
        frame_len = '0;
        rx_crc = 16'hFFFF;
        crc_lo = '0;
        tick_cnt = '0;
      end
      OP_BYTE: begin
        case (rx_phase)
          PH_HEADER: begin
            rx_crc = crc_step(rx_crc, in_rx_byte);
            if (hdr_cnt >= 2'd2) begin
              frame_len = in_rx_byte;
              hdr_cnt = '0;
              rx_phase = (in_rx_byte == 8'd0) ? PH_CRC : PH_DATA;
            end else begin
              hdr_cnt = hdr_cnt + 2'd1;
            end
          end
          PH_DATA: begin
            rx_crc = crc_step(rx_crc, in_rx_byte);
            store[data_cnt] = in_rx_byte;
            data_cnt = data_cnt + 8'd1;
            if (data_cnt >= frame_len) begin
              hdr_cnt = '0;
              rx_phase = PH_CRC;
            end
          end
          PH_CRC: begin
            if (hdr_cnt == 2'd0) begin
              crc_lo = in_rx_byte;
              hdr_cnt = 2'd1;
            end else begin
              hdr_cnt = '0;
              expected_q.push_back(done_result(
                ({in_rx_byte, crc_lo} == rx_crc) ? OUTC_OK : OUTC_CRC, frame_len));
              rx_phase = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (rx_phase != PH_IDLE) begin
          if (tick_cnt >= timeout_reg) begin
            expected_q.push_back(done_result(OUTC_TIMEOUT, frame_len));
            rx_phase = PH_IDLE;
          end else begin
            tick_cnt = tick_cnt + 16'd1;
          end
        end
      end
      default: begin
        w = rw_t'(in_read_width);
        avail = {24'd0, data_cnt};
        nbytes = (w == RW_WORD) ? 32'd2 : (w == RW_DWORD) ? 32'd4 : 32'd1;
        err = 1'b0;
        off = {16'd0, in_read_index};
        val = '0;
        if (in_read_by_register) begin
          if (in_read_index < base_reg) err = 1'b1;
          else begin
            off = {16'd0, in_read_index - base_reg};
            if (w == RW_WORD || w == RW_DWORD) off = off * 2;
          end
        end
        if (!err && off + nbytes > avail) err = 1'b1;
        if (!err) begin
          for (int k = 0; k < nbytes; k++) val = (val << 8) | store[off + k];
          if (w == RW_BIT) val = (val >> in_bit_index) & 32'd1;
        end
        r = '0;
        r.read_valid = 1'b1;
        r.read_value = err ? 32'd0 : val;
        r.read_error = err;
        expected_q.push_back(r);
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      expected_q.delete();
      errors = 0;
      timeout_reg = TIMEOUT_RESET;
      rx_phase = PH_IDLE;
      hdr_cnt = '0;
      data_cnt = '0;
      frame_len = '0;
      rx_crc = 16'hFFFF;
      crc_lo = '0;
      base_reg = '0;
      tick_cnt = '0;
    end else begin
      if (pop && !empty) begin
        got = {out_tx_valid, out_tx_byte, out_tx_last, out_frame_done, out_outcome,
               out_rx_len, out_read_valid, out_read_value, out_read_error};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: tx %0b/%02h/%0b done %0b/%0d/%02h read %0b/%08h/%0b",
                     got.tx_valid, got.tx_byte, got.tx_last, got.frame_done, got.outcome,
                     got.rx_len, got.read_valid, got.read_value, got.read_error);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected tx %0b/%02h/%0b done %0b/%0d/%02h read %0b/%08h/%0b",
                       want.tx_valid, want.tx_byte, want.tx_last, want.frame_done,
                       want.outcome, want.rx_len, want.read_valid, want.read_value,
                       want.read_error);
              $display("          actual   tx %0b/%02h/%0b done %0b/%0d/%02h read %0b/%08h/%0b",
                       got.tx_valid, got.tx_byte, got.tx_last, got.frame_done, got.outcome,
                       got.rx_len, got.read_valid, got.read_value, got.read_error);
            end
          end
        end
      end
      if (cfg_we) timeout_reg = cfg_wdata;
      if (push && !full) predict_transaction();
    end
    pending <= expected_q.size();
    fail_count <= errors;
  end

endmodule

// ===== verif/modbus_rtu_read_transaction_tb.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_read_transaction_tb
// Drives requests, response bytes, ticks and reads into the Modbus RTU read
// block with random gaps and random result stalls, under several timeout
// settings. A separate checker predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module modbus_rtu_read_transaction_tb;
  import mrtu_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;

  typedef logic [7:0] bytes_q[$];

  typedef struct {
    op_t         op;
    logic [7:0]  dev;
    logic [7:0]  func;
    logic [15:0] sreg;
    logic [15:0] cnt;
    logic [7:0]  rxb;
    logic [15:0] idx;
    logic        byreg;
    rw_t         width;
    logic [2:0]  bitpos;
  } stim_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        push, full, empty, pop;
  logic [1:0]  in_op;
  logic [7:0]  in_dev_addr, in_func_code, in_rx_byte;
  logic [15:0] in_start_reg, in_reg_count, in_read_index;
  logic        in_read_by_register;
  logic [1:0]  in_read_width;
  logic [2:0]  in_bit_index;
  logic        out_tx_valid, out_tx_last, out_frame_done, out_read_valid, out_read_error;
  logic [7:0]  out_tx_byte, out_rx_len;
  logic [1:0]  out_outcome;
  logic [31:0] out_read_value;
  int          fail_count, pending;

  int          items_sent;
  int          cur_timeout;
  logic        tx_steady, rx_steady;
  int          idle_cycles;

  modbus_rtu_read_transaction dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .in_op(in_op), .in_dev_addr(in_dev_addr),
    .in_func_code(in_func_code), .in_start_reg(in_start_reg),
    .in_reg_count(in_reg_count), .in_rx_byte(in_rx_byte),
    .in_read_index(in_read_index), .in_read_by_register(in_read_by_register),
    .in_read_width(in_read_width), .in_bit_index(in_bit_index),
    .empty(empty), .pop(pop), .out_tx_valid(out_tx_valid), .out_tx_byte(out_tx_byte),
    .out_tx_last(out_tx_last), .out_frame_done(out_frame_done),
    .out_outcome(out_outcome), .out_rx_len(out_rx_len),
    .out_read_valid(out_read_valid), .out_read_value(out_read_value),
    .out_read_error(out_read_error)
  );

  modbus_rtu_read_transaction_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .in_op(in_op), .in_dev_addr(in_dev_addr),
    .in_func_code(in_func_code), .in_start_reg(in_start_reg),
    .in_reg_count(in_reg_count), .in_rx_byte(in_rx_byte),
    .in_read_index(in_read_index), .in_read_by_register(in_read_by_register),
    .in_read_width(in_read_width), .in_bit_index(in_bit_index),
    .empty(empty), .pop(pop), .out_tx_valid(out_tx_valid), .out_tx_byte(out_tx_byte),
    .out_tx_last(out_tx_last), .out_frame_done(out_frame_done),
    .out_outcome(out_outcome), .out_rx_len(out_rx_len),
    .out_read_valid(out_read_valid), .out_read_value(out_read_value),
    .out_read_error(out_read_error), .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fields that a transaction does not use still carry random values.
  function automatic stim_t noise_item(input op_t op);
    stim_t s;
    s.op = op;
    s.dev = 8'($urandom);
    s.func = 8'($urandom);
    s.sreg = 16'($urandom);
    s.cnt = 16'($urandom);
    s.rxb = 8'($urandom);
    s.idx = 16'($urandom);
    s.byreg = 1'($urandom);
    s.width = rw_t'($urandom_range(0, 3));
    s.bitpos = 3'($urandom);
    return s;
  endfunction

  function automatic stim_t mk_start(input logic [7:0] dev, input logic [7:0] func,
                                     input logic [15:0] sreg, input logic [15:0] cnt);
    stim_t s;
    s = noise_item(OP_START);
    s.dev = dev;
    s.func = func;
    s.sreg = sreg;
    s.cnt = cnt;
    return s;
  endfunction

  function automatic stim_t mk_byte(input logic [7:0] b);
    stim_t s;
    s = noise_item(OP_BYTE);
    s.rxb = b;
    return s;
  endfunction

  function automatic stim_t mk_read(input logic [15:0] idx, input logic byreg,
                                    input rw_t w, input logic [2:0] bitpos);
    stim_t s;
    s = noise_item(OP_READ);
    s.idx = idx;
    s.byreg = byreg;
    s.width = w;
    s.bitpos = bitpos;
    return s;
  endfunction

  function automatic stim_t random_read(input logic [15:0] sreg, input int len);
    stim_t s;
    s = noise_item(OP_READ);
    if ($urandom_range(0, 7) != 0) begin
      if (s.byreg) s.idx = 16'(sreg + $urandom_range(0, len / 2 + 1) -
                               ($urandom_range(0, 9) == 0));
      else s.idx = 16'($urandom_range(0, len + 1));
    end
    return s;
  endfunction

  // Header, data and a correct CRC-16 trailer, low byte first.
  function automatic bytes_q build_frame(input logic [7:0] addr, input logic [7:0] func,
                                         input bytes_q data);
    bytes_q f;
    logic [15:0] c;
    f = {addr, func, 8'(data.size())};
    foreach (data[k]) f.push_back(data[k]);
    c = 16'hFFFF;
    foreach (f[k]) c = crc_byte(c, f[k]);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    return f;
  endfunction

  task automatic send(input stim_t s, input bit counted);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op <= s.op;
    in_dev_addr <= s.dev;
    in_func_code <= s.func;
    in_start_reg <= s.sreg;
    in_reg_count <= s.cnt;
    in_rx_byte <= s.rxb;
    in_read_index <= s.idx;
    in_read_by_register <= s.byreg;
    in_read_width <= s.width;
    in_bit_index <= s.bitpos;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    if (counted) items_sent++;
  endtask

  task automatic send_bytes(input bytes_q f);
    foreach (f[k]) send(mk_byte(f[k]), 1);
  endtask

  task automatic wait_results(input int settle);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    wait_results(SETTLE_CYCLES);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_timeout = v;
    @(posedge clk);
  endtask

  task automatic directed_part();
    bytes_q f;
    send(mk_byte(8'hA5), 0);
    send(noise_item(OP_TICK), 0);
    send(mk_read(16'd0, 1'b0, RW_BYTE, 3'd0), 1);
    send(mk_start(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF), 1);
    send(mk_start(8'h00, 8'h00, 16'h0000, 16'h0000), 1);
    send_bytes(build_frame(8'h01, 8'h03, '{8'h80, 8'hFF, 8'h00, 8'h01}));
    send(mk_read(16'd0, 1'b0, RW_BYTE, 3'd0), 1);
    send(mk_read(16'd2, 1'b0, RW_WORD, 3'd0), 1);
    send(mk_read(16'd0, 1'b0, RW_DWORD, 3'd0), 1);
    send(mk_read(16'd0, 1'b0, RW_BIT, 3'd7), 1);
    send(mk_read(16'd3, 1'b0, RW_BIT, 3'd0), 1);
    send(mk_read(16'd1, 1'b1, RW_WORD, 3'd0), 1);
    send(mk_read(16'd0, 1'b1, RW_DWORD, 3'd0), 1);
    send(mk_read(16'd3, 1'b1, RW_BYTE, 3'd0), 1);
    send(mk_read(16'd3, 1'b0, RW_WORD, 3'd0), 1);
    send(mk_read(16'hFFFF, 1'b0, RW_BYTE, 3'd0), 1);
    // A register number below the start register is refused.
    send(mk_start(8'h11, 8'h04, 16'd100, 16'd2), 1);
    send(mk_read(16'd99, 1'b1, RW_WORD, 3'd0), 1);
    f = {};
    send_bytes(build_frame(8'h11, 8'h04, f));
    send(mk_start(8'h22, 8'h03, 16'd5, 16'd1), 1);
    f = build_frame(8'h22, 8'h03, '{8'h5A});
    f[f.size() - 1] ^= 8'h80;
    send_bytes(f);
  endtask

  task automatic run_session();
    logic [15:0] sreg;
    int          len, kind, cut;
    bytes_q      data, f;
    tx_steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) wait_results(0);
    sreg = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
    send(mk_start(8'($urandom), 8'($urandom), sreg, 16'($urandom)), 1);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    data = {};
    repeat (len) data.push_back(8'($urandom));
    f = build_frame(8'($urandom), 8'($urandom), data);
    kind = $urandom_range(0, 9);
    if (kind == 7) f[f.size() - 1 - $urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
    cut = (kind == 8) ? $urandom_range(0, f.size() - 1) : f.size();
    for (int k = 0; k < cut; k++) begin
      if ($urandom_range(0, 7) == 0) send(random_read(sreg, len), 1);
      if ($urandom_range(0, 9) == 0) send(noise_item(OP_TICK), 1);
      send(mk_byte(f[k]), 1);
    end
    if (kind == 8 && cur_timeout < 16) repeat (cur_timeout + 1) send(noise_item(OP_TICK), 1);
    if (kind == 9) begin
      send(mk_byte(8'($urandom)), 0);
      send(noise_item(OP_TICK), 0);
    end
    repeat ($urandom_range(1, 4)) send(random_read(sreg, len), 1);
  endtask

  task automatic run_until(input int target);
    while (items_sent < target) run_session();
  endtask

  // Result side: random stalls, with stretches of popping every cycle.
  initial begin
    int gap;
    rx_steady = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    push <= 1'b0;
    pop <= 1'b0;
    in_op <= OP_START;
    in_dev_addr <= '0;
    in_func_code <= '0;
    in_start_reg <= '0;
    in_reg_count <= '0;
    in_rx_byte <= '0;
    in_read_index <= '0;
    in_read_by_register <= 1'b0;
    in_read_width <= RW_BYTE;
    in_bit_index <= '0;
    items_sent = 0;
    cur_timeout = TIMEOUT_RESET;
    tx_steady = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();
    run_until(80);
    write_timeout(16'd1);
    run_until(150);
    write_timeout(16'd0);
    // Longest length byte, cut short by the first tick.
    send(mk_start(8'($urandom), 8'($urandom), 16'd0, 16'd8), 1);
    send_bytes('{8'h01, 8'h03, 8'hFF, 8'h10, 8'h20});
    send(noise_item(OP_TICK), 1);
    send(mk_read(16'd0, 1'b0, RW_WORD, 3'd0), 1);
    run_until(220);
    write_timeout(16'hFFFF);
    run_until(270);
    write_timeout(16'($urandom_range(2, 12)));
    run_until(310);

    wait_results(SETTLE_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
